@@ sv/message_rate_and_client_guard_macros.svh @@
// Assertion macros for the message rate and client guard.
// Used by the checker module; depends on nothing else.
// Every macro samples on the rising clock and is disabled while reset is low.

`ifndef MESSAGE_RATE_AND_CLIENT_GUARD_MACROS_SVH
`define MESSAGE_RATE_AND_CLIENT_GUARD_MACROS_SVH

// Same-cycle implication.
`define MRCG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mrcg_pkg.sv @@
// Package for the message rate and client guard: shared types, codes and the client table.
// Depends on nothing; the front end, queue, back end, top level, checker and testbench use it by scoped names.
`timescale 1ns / 1ps

package mrcg_pkg;

    localparam logic [12:0] MIN_LEN      = 13'd20;
    localparam int unsigned CLIENT_COUNT = 5;
    localparam logic [2:0]  GATED_CLIENT = 3'd1;

    localparam logic [63:0] WINDOW_RESET = 64'd1000000000;
    localparam logic [8:0]  LIMIT_RESET  = 9'd20;

    // Client ids, byte 0 of the id in bits 7:0 of the low word.
    localparam logic [63:0] CLIENT_LO [CLIENT_COUNT] = '{
        64'h43451F7301636A8E, 64'h4045459A2802F812, 64'hE011F1F86C9AB705,
        64'hA949583434FFD1E2, 64'h0045A1F603999CFC
    };
    localparam logic [63:0] CLIENT_HI [CLIENT_COUNT] = '{
        64'h3ADAD2DB2B3DEAAD, 64'h66C35B964F239EA7, 64'h000000000000A197,
        64'hE59BCE15698EDA88, 64'h9BACF8A77A0AFE96
    };

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_MGMT   = 2'd2
    } cfg_index_t;

    typedef logic [63:0] stamp_t;

    typedef struct packed {
        logic       known;
        logic [2:0] index;
    } client_match_t;

    typedef struct packed {
        stamp_t        timestamp;
        client_match_t client;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        stamp_t     window_len;
        logic [8:0] burst_limit;
        logic       mgmt_provisioned;
    } cfg_t;

    typedef struct packed {
        logic [8:0]  window_count;
        logic        burst_alert;
        logic        unknown_alert;
        logic        gated_alert;
        logic [2:0]  client_index;
        logic [63:0] message_total;
        logic [63:0] alert_total;
        logic [63:0] unknown_total;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_WALK,
        BK_DONE
    } back_state_t;

    // First matching table entry wins; an unknown id gives index 0.
    function automatic client_match_t client_lookup(input logic [63:0] lo,
                                                    input logic [63:0] hi);
        client_match_t m;
        m.known = 1'b0;
        m.index = 3'd0;
        for (int i = CLIENT_COUNT - 1; i >= 0; i--) begin
            if (CLIENT_LO[i] == lo && CLIENT_HI[i] == hi) begin
                m.known = 1'b1;
                m.index = 3'(i);
            end
        end
        return m;
    endfunction

endpackage

@@ sv/mrcg_if.sv @@
// Handshake interfaces for the message, result and configuration channels.
// Depends on nothing; used by the top level and the front end.
`timescale 1ns / 1ps

interface mrcg_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] timestamp;
    logic [63:0] id_low;
    logic [63:0] id_high;
    logic [12:0] msg_len;

    modport source (output valid, timestamp, id_low, id_high, msg_len, input ready);
    modport sink (input valid, timestamp, id_low, id_high, msg_len, output ready);
endinterface

interface mrcg_out_if;
    logic        valid;
    logic        ready;
    logic [8:0]  window_count;
    logic        burst_alert;
    logic        unknown_alert;
    logic        gated_alert;
    logic [2:0]  client_index;
    logic [63:0] message_total;
    logic [63:0] alert_total;
    logic [63:0] unknown_total;

    modport source (output valid, window_count, burst_alert, unknown_alert, gated_alert,
                    client_index, message_total, alert_total, unknown_total,
                    input ready);
    modport sink (input valid, window_count, burst_alert, unknown_alert, gated_alert,
                  client_index, message_total, alert_total, unknown_total,
                  output ready);
endinterface

interface mrcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/mrcg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the timestamp ring.
`timescale 1ns / 1ps

module mrcg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mrcg_fifo.sv @@
// Two-entry queue of classified work between the front end and the back end.
// Depends on mrcg_pkg.
`timescale 1ns / 1ps

module mrcg_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mrcg_pkg::work_t     wdata,
    input  logic                pop,
    output mrcg_pkg::work_t     head,
    output mrcg_pkg::fifo_stat_t stat
);

    mrcg_pkg::work_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      level_reg;
    logic [1:0]      level_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = level_reg[1];
    assign stat.empty = (level_reg == 2'd0);

endmodule

@@ sv/mrcg_front.sv @@
// Front end: accepts messages, drops short ones and matches the client id.
// Depends on mrcg_pkg and mrcg_if.
`timescale 1ns / 1ps

module mrcg_front (
    mrcg_in_if.sink               msg_in,
    input  mrcg_pkg::fifo_stat_t  qstat,
    output logic                  push,
    output mrcg_pkg::work_t       entry
);

    // Short messages are taken and dropped without touching any state.
    assign msg_in.ready = !qstat.full;
    assign push = msg_in.valid && msg_in.ready && (msg_in.msg_len >= mrcg_pkg::MIN_LEN);

    assign entry.timestamp = msg_in.timestamp;
    assign entry.client    = mrcg_pkg::client_lookup(msg_in.id_low, msg_in.id_high);

endmodule

@@ sv/mrcg_back.sv @@
// Back end: writes the timestamp ring, walks it back over the window and keeps the totals.
// Depends on mrcg_pkg and mrcg_ram.
`timescale 1ns / 1ps

module mrcg_back #(
    parameter int RING_SIZE = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrcg_pkg::cfg_t       cfg,
    input  mrcg_pkg::work_t      head,
    input  mrcg_pkg::fifo_stat_t qstat,
    output logic                 pop,
    output mrcg_pkg::result_t    result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    localparam int AW   = $clog2(RING_SIZE);
    localparam int CW   = $clog2(RING_SIZE + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam logic [AW-1:0] LAST_POS  = AW'(RING_SIZE - 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(RING_SIZE);
    localparam logic [CW-1:0] FULL_LEFT = CW'(RING_SIZE - 1);

    mrcg_pkg::back_state_t  state_reg, state_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          left_reg, left_next;
    logic                   pend_reg, pend_next;
    logic [CW-1:0]          count_reg, count_next;
    mrcg_pkg::stamp_t       now_reg, now_next;
    mrcg_pkg::client_match_t client_reg, client_next;
    logic [63:0]            msg_cnt_reg, msg_cnt_next;
    logic [63:0]            alert_cnt_reg, alert_cnt_next;
    logic [63:0]            unk_cnt_reg, unk_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    mrcg_pkg::result_t      result_reg, result_next;

    logic                   ram_we;
    logic                   ram_re;
    mrcg_pkg::stamp_t       ram_rdata;
    mrcg_pkg::stamp_t       age;
    logic                   hit;
    logic                   miss;
    logic                   walk_end;
    logic                   out_free;
    logic [CMPW-1:0]        count_ext;
    logic                   burst;
    logic                   gated;
    logic [1:0]             alert_add;

    mrcg_ram #(
        .WIDTH (64),
        .DEPTH (RING_SIZE)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (head.timestamp),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // The read issued in the previous cycle is judged here.
    assign age      = now_reg - ram_rdata;
    assign hit      = pend_reg && (age <= cfg.window_len);
    assign miss     = pend_reg && !(age <= cfg.window_len);
    assign walk_end = miss || (!pend_reg && left_reg == '0);
    assign out_free = !out_valid_reg || result_ready;

    assign count_ext = CMPW'(count_reg);
    assign burst     = count_ext > CMPW'(cfg.burst_limit);
    assign gated     = client_reg.known && client_reg.index == mrcg_pkg::GATED_CLIENT
                       && !cfg.mgmt_provisioned;
    assign alert_add = {1'b0, burst} + {1'b0, !client_reg.known} + {1'b0, gated};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrcg_pkg::BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = mrcg_pkg::BK_LOAD;
                end
            end
            mrcg_pkg::BK_LOAD:
            begin
                state_next = mrcg_pkg::BK_WALK;
            end
            mrcg_pkg::BK_WALK:
            begin
                if (walk_end)
                begin
                    state_next = mrcg_pkg::BK_DONE;
                end
            end
            mrcg_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = qstat.empty ? mrcg_pkg::BK_IDLE : mrcg_pkg::BK_LOAD;
                end
            end
            default:
            begin
                state_next = mrcg_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        client_next    = client_reg;
        msg_cnt_next   = msg_cnt_reg;
        alert_cnt_next = alert_cnt_reg;
        unk_cnt_next   = unk_cnt_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            mrcg_pkg::BK_LOAD:
            begin
                // The newest stamp is always inside the window, so it is counted
                // up front and the walk starts one entry further back.
                pop         = 1'b1;
                ram_we      = 1'b1;
                now_next    = head.timestamp;
                client_next = head.client;
                wp_next     = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
                rd_ptr_next = (wp_reg == '0) ? LAST_POS : wp_reg - 1'b1;
                if (fill_reg == FULL_FILL)
                begin
                    left_next = FULL_LEFT;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                    left_next = fill_reg;
                end
                count_next = CW'(1);
                pend_next  = 1'b0;
            end
            mrcg_pkg::BK_WALK:
            begin
                if (hit)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (!miss && left_reg != '0)
                begin
                    ram_re      = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == '0) ? LAST_POS : rd_ptr_reg - 1'b1;
                    left_next   = left_reg - 1'b1;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            mrcg_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    msg_cnt_next   = msg_cnt_reg + 64'd1;
                    alert_cnt_next = alert_cnt_reg + 64'(alert_add);
                    unk_cnt_next   = unk_cnt_reg + 64'(!client_reg.known);
                    out_valid_next = 1'b1;
                    result_next.window_count  = count_ext[8:0];
                    result_next.burst_alert   = burst;
                    result_next.unknown_alert = !client_reg.known;
                    result_next.gated_alert   = gated;
                    result_next.client_index  = client_reg.known ? client_reg.index : 3'd0;
                    result_next.message_total = msg_cnt_next;
                    result_next.alert_total   = alert_cnt_next;
                    result_next.unknown_total = unk_cnt_next;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrcg_pkg::BK_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            msg_cnt_reg   <= '0;
            alert_cnt_reg <= '0;
            unk_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            msg_cnt_reg   <= msg_cnt_next;
            alert_cnt_reg <= alert_cnt_next;
            unk_cnt_reg   <= unk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        count_reg  <= count_next;
        now_reg    <= now_next;
        client_reg <= client_next;
        result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = out_valid_reg;

endmodule

@@ sv/message_rate_and_client_guard.sv @@
// Top level of the message rate and client guard.
// Depends on mrcg_pkg, mrcg_if, mrcg_front, mrcg_fifo, mrcg_back and mrcg_ram.
//
//   Channel     Role     Carries
//   msg_in      sink     timestamp, id_low, id_high, msg_len
//   result_out  source   window count, alert flags, client index, running totals
//   cfg         sink     register index and 64-bit write data
//
// A message of 20 bytes or more passes through the back end in these steps:
// store, one read per older stamp, judge the last read, close the walk and post;
// an idle back end passes its idle state first, and an old stamp ends the walk early.
// A short message is taken and dropped. Reset clears the queue and write pointers, fill
// level and totals; the ring keeps its contents, since the fill level keeps the walk on
// written entries. The two-entry queue takes items while result_out stalls, until full.
`timescale 1ns / 1ps

module message_rate_and_client_guard #(
    parameter int RING_SIZE = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    mrcg_in_if.sink        msg_in,
    mrcg_out_if.source     result_out,
    mrcg_cfg_if.sink       cfg
);

    // Configuration registers. Writes arrive only while the block is idle; the block
    // does not enforce this. The back end reads them directly, with no shadow copy.
    logic [63:0] window_reg;
    logic [8:0]  limit_reg;
    logic        mgmt_reg;

    mrcg_pkg::cfg_t       cfg_now;
    mrcg_pkg::work_t      front_entry;
    mrcg_pkg::work_t      queue_head;
    mrcg_pkg::fifo_stat_t queue_stat;
    mrcg_pkg::result_t    result;
    logic                 front_push;
    logic                 back_pop;
    logic                 result_valid;

    // The register file never stalls a write; an index beyond the list is
    // accepted and has no effect.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= mrcg_pkg::WINDOW_RESET;
            limit_reg  <= mrcg_pkg::LIMIT_RESET;
            mgmt_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (mrcg_pkg::cfg_index_t'(cfg.index))
                mrcg_pkg::CFG_WINDOW: window_reg <= cfg.data;
                mrcg_pkg::CFG_LIMIT:  limit_reg  <= cfg.data[8:0];
                mrcg_pkg::CFG_MGMT:   mgmt_reg   <= cfg.data[0];
                default:              ;
            endcase
        end
    end

    assign cfg_now.window_len       = window_reg;
    assign cfg_now.burst_limit      = limit_reg;
    assign cfg_now.mgmt_provisioned = mgmt_reg;

    // Front end: filters on length and resolves the client id in the accepting cycle.
    mrcg_front u_front (
        .msg_in (msg_in),
        .qstat  (queue_stat),
        .push   (front_push),
        .entry  (front_entry)
    );

    // Short queue so that the front and back ends stall independently.
    mrcg_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_entry),
        .pop   (back_pop),
        .head  (queue_head),
        .stat  (queue_stat)
    );

    // Back end: ring walk, alert decisions and running totals, with its own
    // output register so that a waiting result does not hold up the queue.
    mrcg_back #(
        .RING_SIZE (RING_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_now),
        .head         (queue_head),
        .qstat        (queue_stat),
        .pop          (back_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_out.ready)
    );

    assign result_out.valid         = result_valid;
    assign result_out.window_count  = result.window_count;
    assign result_out.burst_alert   = result.burst_alert;
    assign result_out.unknown_alert = result.unknown_alert;
    assign result_out.gated_alert   = result.gated_alert;
    assign result_out.client_index  = result.client_index;
    assign result_out.message_total = result.message_total;
    assign result_out.alert_total   = result.alert_total;
    assign result_out.unknown_total = result.unknown_total;

endmodule

@@ sv/mrcg_checker.sv @@
// Port-level checks on the result channel of the message rate and client guard.
// Depends on mrcg_pkg and the assertion macros; bound to the top level below.
`timescale 1ns / 1ps
`include "message_rate_and_client_guard_macros.svh"

module mrcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        unknown_alert,
    input logic        gated_alert,
    input logic [2:0]  client_index,
    input logic [63:0] message_total,
    input logic [63:0] alert_total
);

    // A stalled result must stay posted with the same totals.
    `MRCG_ASSERT_NEXT(a_result_held, clk, rst_n, valid && !ready, valid && $stable(message_total) && $stable(alert_total), "stalled result changed")

    // An unknown client carries index zero and never the gated alert.
    `MRCG_ASSERT_IMPLIES(a_unknown_clean, clk, rst_n, valid && unknown_alert, client_index == 3'd0 && !gated_alert, "unknown client with index or gated alert")

    // The gated alert only belongs to the gated client.
    `MRCG_ASSERT_IMPLIES(a_gated_index, clk, rst_n, valid && gated_alert, client_index == mrcg_pkg::GATED_CLIENT, "gated alert on wrong client")

endmodule

bind message_rate_and_client_guard mrcg_checker u_mrcg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result_out.valid),
    .ready         (result_out.ready),
    .unknown_alert (result_out.unknown_alert),
    .gated_alert   (result_out.gated_alert),
    .client_index  (result_out.client_index),
    .message_total (result_out.message_total),
    .alert_total   (result_out.alert_total)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the message rate and client guard: directed messages, then random phases.
// Depends on mrcg_pkg, the mrcg_if interfaces and message_rate_and_client_guard.

module tb;

    // Ring size of the block under test; the walk model below uses the same size.
    localparam int RING_ENTRIES = 256;

    // Index that names no register; a write to it must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // A message of minimum length may still be in the back end, or a short one in the
    // front end, when the last awaited result arrives. This pause is longer than a full
    // walk of the ring, so it covers everything the block can still be doing.
    localparam int SETTLE_CYCLES = RING_ENTRIES + 40;

    localparam logic [63:0] ALL_ONES = '1;

    // How the timestamps of a random phase advance.
    typedef enum {
        PACE_TIGHT,
        PACE_REPEAT,
        PACE_WINDOW,
        PACE_SECONDS,
        PACE_ANY
    } pace_t;

    typedef struct {
        mrcg_pkg::stamp_t timestamp;
        logic [63:0]      id_low;
        logic [63:0]      id_high;
        logic [12:0]      msg_len;
    } message_t;

    // One directed message; where typed is set, want holds the result written out by hand.
    typedef struct {
        message_t          msg;
        bit                typed;
        mrcg_pkg::result_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mrcg_in_if  msg_in ();
    mrcg_out_if result_out ();
    mrcg_cfg_if cfg ();

    message_rate_and_client_guard #(
        .RING_SIZE (RING_ENTRIES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_in     (msg_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Screening model. It holds its own copy of the stamp ring, the write slot,
    // the fill level, the three running totals and the three registers.
    // ------------------------------------------------------------------
    mrcg_pkg::stamp_t seen_stamps [RING_ENTRIES];
    int unsigned      next_slot     = 0;
    int unsigned      stamps_held   = 0;
    logic [63:0]      message_tally = '0;
    logic [63:0]      alert_tally   = '0;
    logic [63:0]      unknown_tally = '0;
    mrcg_pkg::stamp_t window_set    = mrcg_pkg::WINDOW_RESET;
    logic [8:0]       limit_set     = mrcg_pkg::LIMIT_RESET;
    logic             mgmt_set      = 1'b0;

    // Results still owed by the block, oldest first.
    mrcg_pkg::result_t awaited_screens [$];

    directed_row_t directed_rows [$];

    mrcg_pkg::stamp_t last_stamp     = '0;
    int               mismatch_count = 0;
    bit               idling_on      = 1'b1;
    bit               sender_calm    = 1'b0;

    // Works out the result of one message and moves the model on. A message
    // shorter than the minimum gives no result and leaves the state alone.
    function automatic bit screen_message(input message_t m, output mrcg_pkg::result_t r);
        int unsigned recent;
        int          hit;
        bit          burst;
        bit          gated;
        r = '0;
        if (m.msg_len < mrcg_pkg::MIN_LEN)
            return 1'b0;

        message_tally++;
        seen_stamps[next_slot] = m.timestamp;
        next_slot = (next_slot + 1) % RING_ENTRIES;
        if (stamps_held < RING_ENTRIES)
            stamps_held++;

        // Walk back from the newest stamp; ages wrap modulo 2^64, so a stamp from
        // the future looks very old and ends the walk.
        recent = 0;
        while (recent < stamps_held &&
               (m.timestamp -
                seen_stamps[(next_slot + RING_ENTRIES - 1 - recent) % RING_ENTRIES])
               <= window_set)
            recent++;

        burst = (recent > limit_set);
        if (burst)
            alert_tally++;

        hit = -1;
        for (int i = 0; i < mrcg_pkg::CLIENT_COUNT; i++)
            if (hit < 0 && mrcg_pkg::CLIENT_LO[i] == m.id_low &&
                mrcg_pkg::CLIENT_HI[i] == m.id_high)
                hit = i;

        gated = 1'b0;
        if (hit < 0)
        begin
            unknown_tally++;
            alert_tally++;
        end
        else if (hit == mrcg_pkg::GATED_CLIENT && !mgmt_set)
        begin
            gated = 1'b1;
            alert_tally++;
        end

        r.window_count  = recent[8:0];
        r.burst_alert   = burst;
        r.unknown_alert = (hit < 0);
        r.gated_alert   = gated;
        r.client_index  = (hit < 0) ? 3'd0 : 3'(hit);
        r.message_total = message_tally;
        r.alert_total   = alert_tally;
        r.unknown_total = unknown_tally;
        return 1'b1;
    endfunction

    // flags holds burst, unknown and gated alerts, in that order.
    function automatic void add_row(input mrcg_pkg::stamp_t ts, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic [12:0] len,
                                    input bit typed, input logic [8:0] count,
                                    input logic [2:0] flags, input logic [2:0] index,
                                    input logic [63:0] msgs, input logic [63:0] alerts,
                                    input logic [63:0] unknowns);
        directed_row_t row;
        row.msg.timestamp = ts;
        row.msg.id_low    = lo;
        row.msg.id_high   = hi;
        row.msg.msg_len   = len;
        row.typed         = typed;
        row.want.window_count = count;
        {row.want.burst_alert, row.want.unknown_alert, row.want.gated_alert} = flags;
        row.want.client_index  = index;
        row.want.message_total = msgs;
        row.want.alert_total   = alerts;
        row.want.unknown_total = unknowns;
        directed_rows.push_back(row);
    endfunction

    // Random message. Stamps mostly advance at the pace of the phase, now and then
    // jump anywhere or step back a little. Ids are mostly known clients, otherwise
    // random, one bit off a known client, or all zeros or all ones.
    function automatic message_t random_message(input pace_t pace);
        message_t         m;
        mrcg_pkg::stamp_t step;
        int               pick;
        int               k;
        int               b;
        case (pace)
            PACE_TIGHT:   step = $urandom_range(0, 1000);
            PACE_REPEAT:  step = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
            PACE_WINDOW:  step = $urandom_range(0, 200);
            PACE_SECONDS: step = $urandom_range(0, 20_000_000);
            default:      step = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4)
            m.timestamp = {$urandom, $urandom};
        else if (pick < 8)
            m.timestamp = last_stamp - $urandom_range(1, 50);
        else
            m.timestamp = last_stamp + step;
        last_stamp = m.timestamp;

        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, mrcg_pkg::CLIENT_COUNT - 1);
        if (pick < 70)
        begin
            m.id_low  = mrcg_pkg::CLIENT_LO[k];
            m.id_high = mrcg_pkg::CLIENT_HI[k];
        end
        else if (pick < 82)
        begin
            m.id_low  = {$urandom, $urandom};
            m.id_high = {$urandom, $urandom};
        end
        else if (pick < 92)
        begin
            m.id_low  = mrcg_pkg::CLIENT_LO[k];
            m.id_high = mrcg_pkg::CLIENT_HI[k];
            b = $urandom_range(0, 127);
            if (b < 64)
                m.id_low[b] = ~m.id_low[b];
            else
                m.id_high[b - 64] = ~m.id_high[b - 64];
        end
        else
        begin
            m.id_low  = ($urandom_range(0, 1) == 0) ? '0 : ALL_ONES;
            m.id_high = m.id_low;
        end

        pick = $urandom_range(0, 99);
        if (pick < 10)
            m.msg_len = $urandom_range(0, 19);
        else if (pick < 13)
            m.msg_len = 13'd4096;
        else if (pick < 15)
            m.msg_len = mrcg_pkg::MIN_LEN;
        else
            m.msg_len = $urandom_range(20, 4095);
        return m;
    endfunction

    // Offers one item, after a random gap when idling is on, and records what the
    // block owes for it once it has been taken.
    task automatic send_message(input message_t m, input bit typed,
                                input mrcg_pkg::result_t want);
        mrcg_pkg::result_t r;
        int                gap;
        if (idling_on && $urandom_range(0, 19) == 0)
            sender_calm = !sender_calm;
        if (idling_on && !sender_calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            msg_in.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        msg_in.valid     <= 1'b1;
        msg_in.timestamp <= m.timestamp;
        msg_in.id_low    <= m.id_low;
        msg_in.id_high   <= m.id_high;
        msg_in.msg_len   <= m.msg_len;
        @(posedge clk);
        while (!msg_in.ready)
            @(posedge clk);
        if (screen_message(m, r))
            awaited_screens.push_back(typed ? want : r);
    endtask

    // Register write; the model takes the same value, cut to the register's width.
    task automatic write_register(input logic [1:0] reg_index, input logic [63:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= reg_index;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (reg_index)
            mrcg_pkg::CFG_WINDOW: window_set = value;
            mrcg_pkg::CFG_LIMIT:  limit_set  = value[8:0];
            mrcg_pkg::CFG_MGMT:   mgmt_set   = value[0];
            default:              ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // The sender stops until every owed result is in, then lets the block settle,
    // so that registers are only ever written while it is idle.
    task automatic drain_and_settle();
        @(negedge clk);
        msg_in.valid <= 1'b0;
        while (awaited_screens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random phase: runs until the wanted number of full-length messages has gone in;
    // short messages come along but are not counted.
    task automatic run_phase(input pace_t pace, input int wanted);
        message_t          m;
        mrcg_pkg::result_t unused_want;
        int                kept;
        kept        = 0;
        unused_want = '0;
        while (kept < wanted)
        begin
            m = random_message(pace);
            send_message(m, 1'b0, unused_want);
            if (m.msg_len >= mrcg_pkg::MIN_LEN)
                kept++;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker. Every item taken from result_out is held against the oldest
    // owed result, field by field; a result that nobody owes is a failure too.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        mrcg_pkg::result_t want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (awaited_screens.size() == 0)
            begin
                $display("%0t ns: result expected none, got count %0h totals %0h/%0h/%0h",
                         $time, result_out.window_count, result_out.message_total,
                         result_out.alert_total, result_out.unknown_total);
                mismatch_count++;
            end
            else
            begin
                want = awaited_screens.pop_front();
                check_field("window_count", want.window_count, result_out.window_count);
                check_field("burst_alert", want.burst_alert, result_out.burst_alert);
                check_field("unknown_alert", want.unknown_alert, result_out.unknown_alert);
                check_field("gated_alert", want.gated_alert, result_out.gated_alert);
                check_field("client_index", want.client_index, result_out.client_index);
                check_field("message_total", want.message_total, result_out.message_total);
                check_field("alert_total", want.alert_total, result_out.alert_total);
                check_field("unknown_total", want.unknown_total, result_out.unknown_total);
            end
        end
    end

    // ------------------------------------------------------------------
    // Back-pressure on result_out. Stalls come in bursts, and the odds of a burst
    // are redrawn now and then, so some stretches see no stalls at all.
    // ------------------------------------------------------------------
    initial
    begin : result_back_pressure
        int stall_left;
        int stall_odds;
        stall_left = 0;
        stall_odds = 1;
        result_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 299) == 0)
                stall_odds = $urandom_range(0, 2);
            if (!idling_on)
                result_out.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_out.ready <= 1'b0;
            end
            else if ((stall_odds == 1 && $urandom_range(0, 3) == 0) ||
                     (stall_odds == 2 && $urandom_range(0, 31) == 0))
            begin
                stall_left = $urandom_range(0, 10);
                result_out.ready <= 1'b0;
            end
            else
                result_out.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        mrcg_pkg::result_t unused_want;
        unused_want = '0;

        rst_n            = 1'b0;
        msg_in.valid     = 1'b0;
        msg_in.timestamp = '0;
        msg_in.id_low    = '0;
        msg_in.id_high   = '0;
        msg_in.msg_len   = '0;
        cfg.valid        = 1'b0;
        cfg.index        = mrcg_pkg::CFG_WINDOW;
        cfg.data         = '0;
        for (int i = 0; i < RING_ENTRIES; i++)
            seen_stamps[i] = '0;

        // Directed messages under the reset settings: a one-second window, a limit
        // of 20 and management not provisioned. Stamps 0 to 8 all lie in one window,
        // so the count simply grows with each message that is long enough.
        add_row(64'd0, mrcg_pkg::CLIENT_LO[0], mrcg_pkg::CLIENT_HI[0], 13'd20, 1, 9'd1,
                3'b000, 3'd0, 1, 0, 0);
        // The gated client, with a message of 4096 bytes.
        add_row(64'd1, mrcg_pkg::CLIENT_LO[1], mrcg_pkg::CLIENT_HI[1], 13'd4096, 1, 9'd2,
                3'b001, 3'd1, 2, 1, 0);
        // Short messages are dropped without a trace.
        add_row(64'd2, '0, '0, 13'd19, 0, '0, '0, '0, '0, '0, '0);
        add_row(64'd3, ALL_ONES, ALL_ONES, 13'd0, 0, '0, '0, '0, '0, '0, '0);
        // Unknown id: an alert, index 0 and no gated alert.
        add_row(64'd4, ALL_ONES, ALL_ONES, 13'd21, 1, 9'd3, 3'b010, 3'd0, 3, 2, 1);
        add_row(64'd5, mrcg_pkg::CLIENT_LO[2], mrcg_pkg::CLIENT_HI[2], 13'd100, 1, 9'd4,
                3'b000, 3'd2, 4, 2, 1);
        add_row(64'd6, mrcg_pkg::CLIENT_LO[3], mrcg_pkg::CLIENT_HI[3], 13'd2047, 1, 9'd5,
                3'b000, 3'd3, 5, 2, 1);
        add_row(64'd7, mrcg_pkg::CLIENT_LO[4], mrcg_pkg::CLIENT_HI[4], 13'd4095, 1, 9'd6,
                3'b000, 3'd4, 6, 2, 1);
        // Low word of one client with the high word of another is still unknown.
        add_row(64'd8, mrcg_pkg::CLIENT_LO[0], mrcg_pkg::CLIENT_HI[1], 13'd20, 1, 9'd7,
                3'b010, 3'd0, 7, 3, 2);
        // An age of exactly the window still counts; one tick more ends the walk.
        add_row(64'd1000000008, mrcg_pkg::CLIENT_LO[0], mrcg_pkg::CLIENT_HI[0], 13'd20, 1,
                9'd2, 3'b000, 3'd0, 8, 3, 2);
        add_row(64'd3000000000, mrcg_pkg::CLIENT_LO[1], mrcg_pkg::CLIENT_HI[1], 13'd20, 1,
                9'd1, 3'b001, 3'd1, 9, 4, 2);
        // A stamp behind the newest one looks very old, since ages wrap.
        add_row(64'd2999999999, mrcg_pkg::CLIENT_LO[0], mrcg_pkg::CLIENT_HI[0], 13'd20, 1,
                9'd1, 3'b000, 3'd0, 10, 4, 2);
        // Largest stamp, then zero: the age across the wrap is one tick.
        add_row(ALL_ONES, mrcg_pkg::CLIENT_LO[0], mrcg_pkg::CLIENT_HI[0], 13'd20, 1, 9'd1,
                3'b000, 3'd0, 11, 4, 2);
        add_row(64'd0, mrcg_pkg::CLIENT_LO[0], mrcg_pkg::CLIENT_HI[0], 13'd20, 1, 9'd2,
                3'b000, 3'd0, 12, 4, 2);
        add_row(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                13'd19, 0, '0, '0, '0, '0, '0, '0);
        add_row(64'hAAAA_AAAA_AAAA_AAAA, mrcg_pkg::CLIENT_LO[3], mrcg_pkg::CLIENT_HI[3],
                13'd20, 1, 9'd1, 3'b000, 3'd3, 13, 4, 2);
        add_row(64'hAAAA_AAAA_AAAA_AAAB, '0, mrcg_pkg::CLIENT_HI[2], 13'd4096, 0, '0, '0,
                '0, '0, '0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_message(directed_rows[i].msg, directed_rows[i].typed, directed_rows[i].want);
        last_stamp = directed_rows[directed_rows.size() - 1].msg.timestamp;

        // Widest window and a limit equal to the ring size: the count follows the fill
        // level, and a burst can never fire. The spare index is written first and must
        // leave every register alone.
        drain_and_settle();
        write_register(CFG_SPARE, {$urandom, $urandom});
        write_register(mrcg_pkg::CFG_WINDOW, ALL_ONES);
        write_register(mrcg_pkg::CFG_LIMIT, 64'd256);
        write_register(mrcg_pkg::CFG_MGMT, 64'd1);
        run_phase(PACE_TIGHT, 96);

        // Zero window and zero limit: only equal stamps count and every message
        // bursts. Upper data bits are set to show they are dropped.
        drain_and_settle();
        write_register(mrcg_pkg::CFG_WINDOW, 64'd0);
        write_register(mrcg_pkg::CFG_LIMIT, 64'd0);
        write_register(mrcg_pkg::CFG_MGMT, {$urandom, $urandom} & ~64'd1);
        run_phase(PACE_REPEAT, 96);

        // Short window with a limit around the typical count, so bursts come and go.
        drain_and_settle();
        write_register(mrcg_pkg::CFG_WINDOW, 64'd1000);
        write_register(mrcg_pkg::CFG_LIMIT, {$urandom, $urandom_range(0, 127) << 9 |
                                             $urandom_range(1, 30)});
        write_register(mrcg_pkg::CFG_MGMT, {$urandom, $urandom});
        run_phase(PACE_WINDOW, 96);

        // Anything goes: random window, limit and provisioning over random stamps.
        drain_and_settle();
        write_register(mrcg_pkg::CFG_WINDOW, {$urandom, $urandom});
        write_register(mrcg_pkg::CFG_LIMIT, {$urandom, $urandom_range(0, 127) << 9 |
                                             $urandom_range(0, 256)});
        write_register(mrcg_pkg::CFG_MGMT, {$urandom, $urandom});
        run_phase(PACE_ANY, 96);

        // Back to the reset settings, with neither side idling.
        drain_and_settle();
        write_register(mrcg_pkg::CFG_WINDOW, mrcg_pkg::WINDOW_RESET);
        write_register(mrcg_pkg::CFG_LIMIT, 64'(mrcg_pkg::LIMIT_RESET));
        write_register(mrcg_pkg::CFG_MGMT, 64'd0);
        idling_on = 1'b0;
        run_phase(PACE_SECONDS, 96);

        drain_and_settle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("%0t ns: timeout, %0d results still owed", $time, awaited_screens.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/mrcg_pkg.sv
sv/mrcg_if.sv
sv/mrcg_ram.sv
sv/mrcg_fifo.sv
sv/mrcg_front.sv
sv/mrcg_back.sv
sv/message_rate_and_client_guard.sv
sv/mrcg_checker.sv
tb/tb.sv
